// ===== rtl/core/skts_pkg.sv =====
// Package for the sorted key table search block.
// Holds table sizing, field widths, the RAM request bundle and the controller status.
// No dependencies.
package skts_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int SLOT_W      = 8;
    localparam int CFG_W       = 9;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic             busy;
        logic             finish;
        logic [CNT_W-1:0] count;
    } t_ctrl_stat;

endpackage

// ===== rtl/core/skts_ifs.sv =====
// Valid/ready channel interfaces for the sorted key table search block.
// Depends on skts_pkg for field widths.
interface skts_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [skts_pkg::SLOT_W-1:0]  slot;
    logic [skts_pkg::KEY_W-1:0]   key;

    modport source (output valid, action, slot, key, input ready);
    modport sink   (input valid, action, slot, key, output ready);
endinterface

interface skts_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [skts_pkg::SLOT_W-1:0]  match_slot;

    modport source (output valid, found, match_slot, input ready);
    modport sink   (input valid, found, match_slot, output ready);
endinterface

// ===== rtl/core/skts_key_ram.sv =====
// Key table storage: one write port, one read port, registered read data.
// Depends on skts_pkg.
module skts_key_ram (
    input  logic                        i_clk,
    input  skts_pkg::t_ram_req          i_req,
    output logic [skts_pkg::KEY_W-1:0]  o_rdata
);

    logic [skts_pkg::KEY_W-1:0] r_mem [skts_pkg::TABLE_DEPTH];
    logic [skts_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/skts_search_ctrl.sv =====
// Search sequencer: takes items, drives the key RAM one probe per cycle, holds the result.
// Depends on skts_pkg and skts_ifs.
module skts_search_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [skts_pkg::CFG_W-1:0]   i_cfg_wdata,
    skts_req_if.sink                     i_req,
    skts_rsp_if.source                   o_rsp,
    output skts_pkg::t_ram_req           o_ram_req,
    input  logic [skts_pkg::KEY_W-1:0]   i_ram_rdata,
    output skts_pkg::t_ctrl_stat         o_stat
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_PROBE  = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [skts_pkg::CNT_W-1:0]    r_count, n_count;
    logic [skts_pkg::CNT_W-1:0]    r_lo, n_lo;
    logic [skts_pkg::CNT_W-1:0]    r_hix, n_hix;
    logic [skts_pkg::ADDR_W-1:0]   r_mid, n_mid;
    logic [skts_pkg::KEY_W-1:0]    r_key, n_key;
    logic                          r_hit, n_hit;
    logic [skts_pkg::ADDR_W-1:0]   r_pos, n_pos;
    logic                          r_out_valid, n_out_valid;
    logic                          r_found, n_found;
    logic [skts_pkg::SLOT_W-1:0]   r_match, n_match;

    logic                          accept;
    logic [skts_pkg::CNT_W-1:0]    lo_nx, hix_nx;

    // midpoint of [lo, hix), caller guarantees lo < hix
    function automatic logic [skts_pkg::ADDR_W-1:0] mid_of(
        input logic [skts_pkg::CNT_W-1:0] lo,
        input logic [skts_pkg::CNT_W-1:0] hix
    );
        logic [skts_pkg::CNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hix} - (skts_pkg::CNT_W+1)'(1);
        return skts_pkg::ADDR_W'(sum >> 1);
    endfunction

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hix       = r_hix;
        n_mid       = r_mid;
        n_key       = r_key;
        n_hit       = r_hit;
        n_pos       = r_pos;
        n_found     = r_found;
        n_match     = r_match;
        n_out_valid = r_out_valid;
        lo_nx       = r_lo;
        hix_nx      = r_hix;
        o_ram_req   = '0;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            if (32'(i_cfg_wdata) > skts_pkg::TABLE_DEPTH) begin
                n_count = skts_pkg::CNT_W'(skts_pkg::TABLE_DEPTH);
            end else begin
                n_count = skts_pkg::CNT_W'(i_cfg_wdata);
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.action == skts_pkg::ACT_WRITE) begin
                        if (32'(i_req.slot) < skts_pkg::TABLE_DEPTH) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = skts_pkg::ADDR_W'(i_req.slot);
                            o_ram_req.wdata = i_req.key;
                        end
                    end else begin
                        n_key = i_req.key;
                        if (r_count == '0) begin
                            n_hit   = 1'b0;
                            n_pos   = '0;
                            n_state = ST_FINISH;
                        end else begin
                            n_lo            = '0;
                            n_hix           = r_count;
                            n_mid           = mid_of('0, r_count);
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = n_mid;
                            n_state         = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE: begin
                if (i_ram_rdata == r_key) begin
                    n_hit   = 1'b1;
                    n_pos   = r_mid;
                    n_state = ST_FINISH;
                end else begin
                    if (i_ram_rdata < r_key) begin
                        lo_nx = skts_pkg::CNT_W'(r_mid) + skts_pkg::CNT_W'(1);
                    end else begin
                        hix_nx = skts_pkg::CNT_W'(r_mid);
                    end
                    n_lo  = lo_nx;
                    n_hix = hix_nx;
                    if (lo_nx < hix_nx) begin
                        n_mid           = mid_of(lo_nx, hix_nx);
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = n_mid;
                    end else begin
                        n_hit   = 1'b0;
                        n_pos   = '0;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_match     = skts_pkg::SLOT_W'(r_pos);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hix   <= n_hix;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_hit   <= n_hit;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_match <= n_match;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.match_slot = r_match;

    assign o_stat.busy   = (r_state != ST_IDLE);
    assign o_stat.finish = (r_state == ST_FINISH) && (!r_out_valid || o_rsp.ready);
    assign o_stat.count  = r_count;

endmodule

// ===== rtl/core/sorted_key_table_search.sv =====
// Sorted key table search: a 256-entry table of 16-bit keys with binary-search lookup.
//
// Channels: i_req carries items (action, slot, key); action 0 writes key at slot and gives
// no result, action 1 looks up key and gives one result item on o_rsp (found, match_slot).
// i_cfg_we / i_cfg_wdata set entry_count, saturated to the table depth; the lookup covers
// positions 0 to entry_count-1. Write the count only while the block is idle.
// Occupancy: a write item leaves the block idle, so i_req.ready stays high. A lookup item
// holds i_req.ready low after acceptance through P probes and the finish state, P being
// the number of probes (at most ceil(log2(entry_count+1)), 9 for a full table).
// One key RAM read per cycle sets the probe rate: the read data of one probe is compared
// and the next midpoint address issued in the same cycle.
// Result: after the last probe, the finish state loads the output register that drives o_rsp.
// Stall: the result waits in the output register; the block keeps taking items, and a
// finished lookup waits in its last state until the output register frees.
// Reset: entry_count clears to 0 and no result is pending; table contents are undefined
// until written.
// Depends on skts_pkg, skts_ifs, skts_key_ram, skts_search_ctrl.
module sorted_key_table_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [skts_pkg::CFG_W-1:0]  i_cfg_wdata,
    skts_req_if.sink                    i_req,
    skts_rsp_if.source                  o_rsp
);

    skts_pkg::t_ram_req               ram_req;
    logic [skts_pkg::KEY_W-1:0]       ram_rdata;
    skts_pkg::t_ctrl_stat             stat;

    skts_search_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_stat      (stat)
    );

    skts_key_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_req.we && ram_req.re))
        else $error("key RAM written and read in the same cycle");

    a_busy_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> !i_req.ready)
        else $error("item taken while a lookup is in flight");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.re |-> (skts_pkg::CNT_W'(ram_req.raddr) < stat.count))
        else $error("probe beyond entries in use");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(stat.finish))
        else $error("result item without a finished lookup");
`endif

endmodule
